### rtl/core/edge_flag_coverage_blend_core_defines.svh
// ---------------------------------------------------------------------------
// Edge flag coverage blend assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef EDGE_FLAG_COVERAGE_BLEND_CORE_DEFINES_SVH
`define EDGE_FLAG_COVERAGE_BLEND_CORE_DEFINES_SVH

// same-cycle implication
`define EFCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/efcb_pkg.sv
// ---------------------------------------------------------------------------
// Edge flag coverage blend package
// Payload types, lane control struct, register map and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package efcb_pkg;

  localparam int SUBPIXELS_DEF    = 8;
  localparam int WINDING_BITS_DEF = 8;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  typedef struct packed {
    logic [7:0]  edge_flags;
    logic [63:0] winding_deltas;
    logic [31:0] dest_pixel;
    logic        span_start;
    logic        fill_start;
  } pix_t;

  typedef struct packed {
    logic [31:0] blended_pixel;
    logic [3:0]  coverage;
  } res_t;

  typedef struct packed {
    logic accept;
    logic flag;
    logic fill_start;
    logic nonzero;
  } lane_ctrl_t;

  typedef enum logic {
    REG_FILL_COLOR = 1'b0,
    REG_FILL_RULE  = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

### rtl/core/efcb_lane.sv
// ---------------------------------------------------------------------------
// Edge flag coverage blend winding lane
// One sub-row winding accumulator; flags a mask toggle on a zero crossing.
// ---------------------------------------------------------------------------
`default_nettype none

module efcb_lane
  import efcb_pkg::*;
#(
  parameter int WINDING_BITS = WINDING_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lane_ctrl_t              ctrl,
  input  wire logic [WINDING_BITS-1:0] delta,
  output logic                         toggle
);

  logic [WINDING_BITS-1:0] sum;
  logic [WINDING_BITS-1:0] sum_base;
  logic [WINDING_BITS-1:0] sum_next;

  always_comb begin
    sum_base = ctrl.fill_start ? '0 : sum;
    sum_next = sum_base + delta;
    toggle   = ctrl.flag && ((sum_base == '0) != (sum_next == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.accept) begin
      if (ctrl.nonzero && ctrl.flag) begin
        sum <= sum_next;
      end else begin
        sum <= sum_base;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/efcb_blend.sv
// ---------------------------------------------------------------------------
// Edge flag coverage blend merge stage
// Weights each byte by coverage, then scales by 1/SUBPIXELS into the output.
// ---------------------------------------------------------------------------
`default_nettype none

module efcb_blend
  import efcb_pkg::*;
#(
  parameter int SUBPIXELS = SUBPIXELS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 a_valid,
  input  wire logic [$clog2(SUBPIXELS+1)-1:0]       a_cov,
  input  wire logic [31:0]                          a_dest,
  input  wire logic [31:0]                          color,
  input  wire logic                                 res_ready,
  output logic                                      take,
  output logic                                      res_valid,
  output res_t                                      res
);

  localparam int CW  = $clog2(SUBPIXELS + 1);
  localparam int PW  = 8 + CW + 1;
  localparam int SW  = $clog2(255 * SUBPIXELS + 1);
  localparam int RK  = 16;
  localparam int RM  = ((1 << RK) + SUBPIXELS - 1) / SUBPIXELS;
  localparam int RMW = $clog2(RM + 1);

  logic              b_valid;
  logic [CW-1:0]     b_cov;
  logic [3:0][SW-1:0] b_sum;
  logic [3:0][SW-1:0] b_sum_next;
  logic [CW-1:0]     inv;
  logic [PW-1:0]     wsum;
  logic [SW+RMW-1:0] scaled;
  logic [31:0]       pix_next;
  logic              en_c;

  assign en_c = !res_valid || res_ready;
  assign take = !b_valid || en_c;

  always_comb begin
    inv = CW'(SUBPIXELS) - a_cov;
    b_sum_next = '0;
    wsum = '0;
    for (int n = 0; n < 4; n++) begin
      wsum = PW'(a_dest[8*n +: 8]) * PW'(inv) + PW'(color[8*n +: 8]) * PW'(a_cov);
      b_sum_next[n] = SW'(wsum);
    end
  end

  always_comb begin
    pix_next = '0;
    scaled = '0;
    for (int n = 0; n < 4; n++) begin
      scaled = (SW+RMW)'(b_sum[n]) * (SW+RMW)'(RM);
      pix_next[8*n +: 8] = scaled[RK +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        res_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && a_valid) begin
      b_sum <= b_sum_next;
      b_cov <= a_cov;
    end
    if (en_c && b_valid) begin
      res.blended_pixel <= pix_next;
      res.coverage      <= 4'(b_cov);
    end
  end

endmodule

`default_nettype wire

### rtl/core/edge_flag_coverage_blend_core.sv
// ---------------------------------------------------------------------------
// Edge flag coverage blend core
// Scanline edge-flag fill: running coverage mask, winding lanes and blend.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter on pix (pix_valid/pix_ready) and results leave on res
//   (res_valid/res_ready); a transfer happens when valid and ready are high.
//   One pixel per clock is accepted while the result side keeps up.
//   A result is registered in stages after its pixel's transfer: the
//   transfer edge updates the mask and winding lanes, the next stage
//   forms the weighted byte sums, and the one after that scales them
//   into the output register.
//   Sustained throughput is one pixel per cycle while res_ready stays high;
//   the rate is set by the mask and accumulator update loop.
//   When res_ready is low, the three stages fill and then pix_ready drops
//   until the result is taken; nothing is lost or repeated.
//   Reset (rst, synchronous) clears the mask, winding sums, fill_color,
//   fill_rule and all stage valids.
//   fill_color (address 0) and fill_rule (address 4) go over the APB port;
//   the user must write them only while the pipeline is empty; the block itself does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "edge_flag_coverage_blend_core_defines.svh"

module edge_flag_coverage_blend_core
  import efcb_pkg::*;
#(
  parameter int SUBPIXELS    = SUBPIXELS_DEF,
  parameter int WINDING_BITS = WINDING_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  wire logic               pix_valid,
  output logic                    pix_ready,
  input  wire pix_t               pix,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output res_t                    res
);

  localparam int CW = $clog2(SUBPIXELS + 1);

  logic [31:0]          fill_color;
  logic                 fill_rule;
  logic [SUBPIXELS-1:0] mask;
  logic [SUBPIXELS-1:0] mask_base;
  logic [SUBPIXELS-1:0] mask_next;
  logic [SUBPIXELS-1:0] toggles;
  logic [CW-1:0]        cov_next;
  logic                 a_valid;
  logic [CW-1:0]        a_cov;
  logic [31:0]          a_dest;
  logic                 take_b;
  logic                 accept;
  logic                 cfg_write;
  reg_idx_t             cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= '0;
      fill_rule  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_FILL_COLOR: fill_color <= pwdata;
        REG_FILL_RULE:  fill_rule  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FILL_COLOR: prdata = fill_color;
      REG_FILL_RULE:  prdata = {{(PDATA_W-1){1'b0}}, fill_rule};
      default:        prdata = '0;
    endcase
  end

  assign pix_ready = !a_valid || take_b;
  assign accept    = pix_valid && pix_ready;

  for (genvar n = 0; n < SUBPIXELS; n++) begin : g_lane
    lane_ctrl_t ctrl;

    always_comb begin
      ctrl.accept     = accept;
      ctrl.flag       = pix.edge_flags[n];
      ctrl.fill_start = pix.fill_start;
      ctrl.nonzero    = fill_rule;
    end

    efcb_lane #(
      .WINDING_BITS(WINDING_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .delta (pix.winding_deltas[8*n +: WINDING_BITS]),
      .toggle(toggles[n])
    );
  end

  always_comb begin
    mask_base = pix.span_start ? '0 : mask;
    if (fill_rule) begin
      mask_next = mask_base ^ toggles;
    end else begin
      mask_next = mask_base ^ pix.edge_flags[SUBPIXELS-1:0];
    end
    cov_next = '0;
    for (int i = 0; i < SUBPIXELS; i++) begin
      cov_next = cov_next + CW'(mask_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask    <= '0;
      a_valid <= 1'b0;
    end else begin
      if (accept) begin
        mask <= mask_next;
      end
      if (pix_ready) begin
        a_valid <= pix_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cov  <= cov_next;
      a_dest <= pix.dest_pixel;
    end
  end

  efcb_blend #(
    .SUBPIXELS(SUBPIXELS)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .a_valid  (a_valid),
    .a_cov    (a_cov),
    .a_dest   (a_dest),
    .color    (fill_color),
    .res_ready(res_ready),
    .take     (take_b),
    .res_valid(res_valid),
    .res      (res)
  );

  `EFCB_ASSERT_NOW(a_cov_range, res_valid, res.coverage <= 4'(SUBPIXELS), "coverage out of range")
  `EFCB_ASSERT_NOW(a_stall_src, !pix_ready, res_valid && !res_ready, "input stalled without output stall")
  `EFCB_ASSERT_NEXT(a_eo_span, accept && pix.span_start && !fill_rule && !cfg_write, mask == $past(pix.edge_flags[SUBPIXELS-1:0]), "even-odd span start mask mismatch")

endmodule

`default_nettype wire
